// ===== src/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// shared types and constants of the keyed value table
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W      = 16;
  localparam int VAL_W      = 32;
  localparam int ENTRY_W    = KEY_W + VAL_W;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(SLOT_COUNT);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_ERASE = 2'd2
  } act_t;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [KEY_W-1:0] entry_key;
    logic signed [VAL_W-1:0] write_value;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic                    status;
  } res_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [SLOT_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== src/kvt_ram.sv =====
// ----------------------------------------------------------------------------
// kvt_ram
// single port synchronous ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/kvt_engine.sv =====
// ----------------------------------------------------------------------------
// kvt_engine
// scan sequencer: walks all slots, finds match and first free, then for write or erase updates
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_engine (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire kvt_pkg::item_t                  in_item,
  output kvt_pkg::ram_req_t                    ram_req,
  input  wire logic [kvt_pkg::ENTRY_W-1:0]     ram_rdata,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output kvt_pkg::res_t                        res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_RESP
  } state_t;

  state_t                         state_r, state_nxt;
  logic [kvt_pkg::SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [kvt_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           chk_r, chk_nxt;
  logic                           hit_r, hit_nxt;
  logic                           free_r, free_nxt;

  logic [kvt_pkg::SLOT_W-1:0]     chk_addr_r, chk_addr_nxt;
  logic [kvt_pkg::SLOT_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [kvt_pkg::SLOT_W-1:0]     free_idx_r, free_idx_nxt;
  logic signed [kvt_pkg::VAL_W-1:0] hit_val_r, hit_val_nxt;
  kvt_pkg::item_t                 item_r, item_nxt;
  kvt_pkg::res_t                  res_r, res_nxt;

  logic                           slot_v;
  logic                           key_eq;

  assign slot_v = valid_r[chk_addr_r];
  assign key_eq = ram_rdata[kvt_pkg::KEY_W-1:0] == item_r.entry_key;

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    chk_nxt      = 1'b0;
    hit_nxt      = hit_r;
    free_nxt     = free_r;
    chk_addr_nxt = chk_addr_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    hit_val_nxt  = hit_val_r;
    item_nxt     = item_r;
    res_nxt      = res_r;
    ram_req      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r != kvt_pkg::SLOT_END) begin
          ram_req.en   = 1'b1;
          ram_req.addr = cnt_r[kvt_pkg::SLOT_W-1:0];
          chk_nxt      = 1'b1;
          chk_addr_nxt = cnt_r[kvt_pkg::SLOT_W-1:0];
          cnt_nxt      = cnt_r + 1'b1;
        end
        if (chk_r) begin
          if (slot_v && key_eq && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = chk_addr_r;
            hit_val_nxt = ram_rdata[kvt_pkg::ENTRY_W-1:kvt_pkg::KEY_W];
          end
          if (!slot_v && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_addr_r;
          end
          if (cnt_r == kvt_pkg::SLOT_END) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        res_nxt       = '0;
        res_nxt.found = hit_r;
        ram_req.wdata = {item_r.write_value, item_r.entry_key};
        unique case (item_r.action)
          kvt_pkg::ACT_WRITE: begin
            if (hit_r) begin
              ram_req.en   = 1'b1;
              ram_req.we   = 1'b1;
              ram_req.addr = hit_idx_r;
            end else if (free_r) begin
              ram_req.en            = 1'b1;
              ram_req.we            = 1'b1;
              ram_req.addr          = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          kvt_pkg::ACT_READ: begin
            if (hit_r) begin
              res_nxt.read_value = hit_val_r;
            end
          end
          kvt_pkg::ACT_ERASE: begin
            if (hit_r) begin
              valid_nxt[hit_idx_r] = 1'b0;
            end
          end
          default: begin
            res_nxt.found = 1'b0;
          end
        endcase
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      cnt_r   <= '0;
      chk_r   <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      chk_r   <= chk_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
  end

  assign in_ready  = state_r == ST_IDLE;
  assign res_valid = state_r == ST_RESP;
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== src/keyed_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_value_table_unit
// associative key/value table with first free slot allocation
// ----------------------------------------------------------------------------
// Every request (write, read or erase) walks all SLOT_COUNT slots through the
// single port of the entry ram, one slot per cycle, then passes the finish and
// response states; a new request is taken only once the result has moved into
// the output register, so requests do not overlap.
// Keys and values live in the ram; the valid marks are flip-flops cleared by
// reset, so no clearing pass runs and the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_value_table_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [1:0] action, [17:2] entry_key, [49:18] write_value, [55:50] zero
  input  wire logic [kvt_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] read_value, [32] found, [33] status, [39:34] zero
  output logic [kvt_pkg::OUT_DATA_W-1:0]         out_tdata
);

  kvt_pkg::item_t                 item;
  kvt_pkg::ram_req_t              ram_req;
  logic [kvt_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                           res_valid;
  logic                           res_ready;
  kvt_pkg::res_t                  res;
  logic                           out_valid_r;
  kvt_pkg::res_t                  out_res_r;

  assign item.action      = in_tdata[1:0];
  assign item.entry_key   = in_tdata[17:2];
  assign item.write_value = in_tdata[49:18];

  kvt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  kvt_ram #(
    .WIDTH (kvt_pkg::ENTRY_W),
    .DEPTH (kvt_pkg::SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.found, out_res_r.read_value};

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid)
    else $error("engine accepts input while presenting a result");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_tvalid)
    else $error("result transfer did not reach the output register");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> !in_tready && !res_valid)
    else $error("entry ram written outside the update step");

endmodule

`default_nettype wire
